>>> hdl/assert_macros.svh
// Assertion macros shared by the decoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition in the same cycle as its trigger
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/sgrd_pkg.sv
// Types and constants of the SGR attribute decoder
`timescale 1ns / 1ps

package sgrd_pkg;

    localparam int PARAM_WIDTH_DEF = 16;

    // SGR parameter codes
    localparam int SGR_RESET      = 0;
    localparam int SGR_BOLD       = 1;
    localparam int SGR_DIM        = 2;
    localparam int SGR_ITALIC     = 3;
    localparam int SGR_UNDER      = 4;
    localparam int SGR_BLINK      = 5;
    localparam int SGR_REVERSE    = 7;
    localparam int SGR_INVIS      = 8;
    localparam int SGR_STRIKE     = 9;
    localparam int SGR_DBL_UNDER  = 21;
    localparam int SGR_NORMAL     = 22;
    localparam int SGR_NO_ITALIC  = 23;
    localparam int SGR_NO_UNDER   = 24;
    localparam int SGR_NO_BLINK   = 25;
    localparam int SGR_NO_REVERSE = 27;
    localparam int SGR_NO_INVIS   = 28;
    localparam int SGR_NO_STRIKE  = 29;
    localparam int SGR_FG_LO      = 30;
    localparam int SGR_FG_HI      = 37;
    localparam int SGR_FG_EXT     = 38;
    localparam int SGR_FG_DEF     = 39;
    localparam int SGR_BG_LO      = 40;
    localparam int SGR_BG_HI      = 47;
    localparam int SGR_BG_EXT     = 48;
    localparam int SGR_BG_DEF     = 49;
    localparam int SGR_UL_EXT     = 58;
    localparam int SGR_FG_BR_LO   = 90;
    localparam int SGR_FG_BR_HI   = 97;
    localparam int SGR_BG_BR_LO   = 100;
    localparam int SGR_BG_BR_HI   = 107;

    // Extended colour selectors
    localparam int SGR_EXT_INDEXED = 5;
    localparam int SGR_EXT_RGB     = 2;
    localparam logic [2:0] SKIP_INDEXED = 3'd1;
    localparam logic [2:0] SKIP_RGB     = 3'd3;

    localparam int COLOR_BRIGHT = 8;

    // Style bit positions
    localparam int ST_BOLD    = 0;
    localparam int ST_DIM     = 1;
    localparam int ST_ITALIC  = 2;
    localparam int ST_UNDER   = 3;
    localparam int ST_BLINK   = 4;
    localparam int ST_REVERSE = 5;
    localparam int ST_INVIS   = 6;
    localparam int ST_STRIKE  = 7;

    typedef enum logic [1:0] {
        KIND_NONE      = 2'd0,
        KIND_UNDERLINE = 2'd1,
        KIND_EXTENDED  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] style;
        logic       fore_indexed;
        logic [3:0] fore_index;
        logic       back_indexed;
        logic [3:0] back_index;
    } t_pen;

    typedef struct packed {
        t_kind      kind;
        logic [2:0] skip;
        logic       base_next;
    } t_seq;

    typedef struct packed {
        logic sub;
        logic first;
        logic last;
        logic none;
        logic inter;
    } t_item;

    localparam t_seq SEQ_RESET = '{kind: KIND_NONE, skip: 3'd0, base_next: 1'b1};

endpackage

>>> hdl/sgrd_step.sv
// Next pen and sequence state for one SGR parameter
`timescale 1ns / 1ps

module sgrd_step
    import sgrd_pkg::*;
#(
    parameter int PARAM_WIDTH = PARAM_WIDTH_DEF
) (
    input  logic [PARAM_WIDTH-1:0] i_value,
    input  t_item                  i_flags,
    input  t_pen                   i_pen,
    input  t_seq                   i_seq,
    output t_pen                   o_pen,
    output t_seq                   o_seq
);

    t_pen pen;
    t_seq seq;

    always_comb begin
        pen = i_pen;
        seq = i_seq;
        if (!i_flags.inter) begin
            if (i_flags.none) begin
                pen = '0;
                seq = SEQ_RESET;
            end else begin
                if (i_flags.first) begin
                    seq = SEQ_RESET;
                end
                if (seq.skip != 3'd0) begin
                    seq.skip = seq.skip - 3'd1;
                    if (seq.skip == 3'd0) begin
                        seq.base_next = 1'b1;
                    end
                end else if (!seq.base_next && i_flags.sub) begin
                    if (seq.kind == KIND_UNDERLINE && i_value == '0) begin
                        pen.style[ST_UNDER] = 1'b0;
                    end
                    seq.kind = KIND_NONE;
                end else if (seq.kind == KIND_EXTENDED && !seq.base_next
                             && (i_value == PARAM_WIDTH'(SGR_EXT_INDEXED)
                                 || i_value == PARAM_WIDTH'(SGR_EXT_RGB))) begin
                    seq.kind = KIND_NONE;
                    seq.skip = (i_value == PARAM_WIDTH'(SGR_EXT_INDEXED)) ?
                               SKIP_INDEXED : SKIP_RGB;
                end else begin
                    seq.base_next = 1'b0;
                    seq.kind      = KIND_NONE;
                    unique case (32'(i_value)) inside
                        SGR_RESET:      pen = '0;
                        SGR_BOLD:       pen.style[ST_BOLD]    = 1'b1;
                        SGR_DIM:        pen.style[ST_DIM]     = 1'b1;
                        SGR_ITALIC:     pen.style[ST_ITALIC]  = 1'b1;
                        SGR_UNDER: begin
                            pen.style[ST_UNDER] = 1'b1;
                            seq.kind            = KIND_UNDERLINE;
                        end
                        SGR_BLINK:      pen.style[ST_BLINK]   = 1'b1;
                        SGR_REVERSE:    pen.style[ST_REVERSE] = 1'b1;
                        SGR_INVIS:      pen.style[ST_INVIS]   = 1'b1;
                        SGR_STRIKE:     pen.style[ST_STRIKE]  = 1'b1;
                        SGR_DBL_UNDER:  pen.style[ST_UNDER]   = 1'b1;
                        SGR_NORMAL: begin
                            pen.style[ST_BOLD] = 1'b0;
                            pen.style[ST_DIM]  = 1'b0;
                        end
                        SGR_NO_ITALIC:  pen.style[ST_ITALIC]  = 1'b0;
                        SGR_NO_UNDER:   pen.style[ST_UNDER]   = 1'b0;
                        SGR_NO_BLINK:   pen.style[ST_BLINK]   = 1'b0;
                        SGR_NO_REVERSE: pen.style[ST_REVERSE] = 1'b0;
                        SGR_NO_INVIS:   pen.style[ST_INVIS]   = 1'b0;
                        SGR_NO_STRIKE:  pen.style[ST_STRIKE]  = 1'b0;
                        SGR_FG_DEF: begin
                            pen.fore_indexed = 1'b0;
                            pen.fore_index   = 4'd0;
                        end
                        SGR_BG_DEF: begin
                            pen.back_indexed = 1'b0;
                            pen.back_index   = 4'd0;
                        end
                        SGR_FG_EXT, SGR_BG_EXT, SGR_UL_EXT: seq.kind = KIND_EXTENDED;
                        [SGR_FG_LO:SGR_FG_HI]: begin
                            pen.fore_indexed = 1'b1;
                            pen.fore_index   = i_value[3:0] - 4'(SGR_FG_LO);
                        end
                        [SGR_BG_LO:SGR_BG_HI]: begin
                            pen.back_indexed = 1'b1;
                            pen.back_index   = i_value[3:0] - 4'(SGR_BG_LO);
                        end
                        [SGR_FG_BR_LO:SGR_FG_BR_HI]: begin
                            pen.fore_indexed = 1'b1;
                            pen.fore_index   = i_value[3:0]
                                               - 4'(SGR_FG_BR_LO - COLOR_BRIGHT);
                        end
                        [SGR_BG_BR_LO:SGR_BG_BR_HI]: begin
                            pen.back_indexed = 1'b1;
                            pen.back_index   = i_value[3:0]
                                               - 4'(SGR_BG_BR_LO - COLOR_BRIGHT);
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    assign o_pen = pen;
    assign o_seq = seq;

endmodule

>>> hdl/sgr_attribute_decoder_core.sv
// SGR attribute decoder: one parameter per cycle unless stalled, pen reported at sequence end
//
// Takes one SGR parameter per transfer and keeps the current pen (eight style
// flags, default or indexed foreground and background). Each parameter is
// registered at the input and applied to the pen by the decode step; a
// parameter that ends a sequence (or an empty sequence) loads the result
// register, so a result passes through the input register and the result
// register before it can transfer.
// The input takes a new parameter every cycle; it stalls only when a
// sequence end waits on a full result register whose transfer is held off.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sgr_attribute_decoder_core
    import sgrd_pkg::*;
#(
    parameter int PARAM_WIDTH = PARAM_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [PARAM_WIDTH-1:0] i_param_value,
    input  logic                   i_is_subparam,
    input  logic                   i_first_param,
    input  logic                   i_last_param,
    input  logic                   i_no_params,
    input  logic                   i_has_intermediates,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_accepted,
    output logic [7:0]             o_style_flags,
    output logic                   o_fore_indexed,
    output logic [3:0]             o_fore_index,
    output logic                   o_back_indexed,
    output logic [3:0]             o_back_index
);

    logic                   r_s1_valid;
    logic [PARAM_WIDTH-1:0] r_s1_value;
    t_item                  r_s1;
    t_pen                   r_pen;
    t_seq                   r_seq;
    logic                   r_out_valid;
    logic                   r_out_accepted;
    t_pen                   r_out_pen;
    t_pen                   n_pen;
    t_seq                   n_seq;
    logic                   s1_res;
    logic                   out_free;
    logic                   s1_fire;
    logic                   in_ready;
    logic                   in_fire;

    assign s1_res   = r_s1.last | r_s1.none;
    assign out_free = !r_out_valid || !i_out_stall;
    assign s1_fire  = r_s1_valid && (!s1_res || out_free);
    assign in_ready = !r_s1_valid || s1_fire;
    assign in_fire  = i_in_valid && in_ready;

    sgrd_step #(
        .PARAM_WIDTH(PARAM_WIDTH)
    ) u_step (
        .i_value (r_s1_value),
        .i_flags (r_s1),
        .i_pen   (r_pen),
        .i_seq   (r_seq),
        .o_pen   (n_pen),
        .o_seq   (n_seq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_pen       <= '0;
            r_seq       <= SEQ_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_fire) begin
                r_pen <= n_pen;
                r_seq <= n_seq;
            end
            if (s1_fire && s1_res) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_value <= i_param_value;
            r_s1       <= '{sub: i_is_subparam, first: i_first_param, last: i_last_param,
                            none: i_no_params, inter: i_has_intermediates};
        end
        if (s1_fire && s1_res) begin
            r_out_accepted <= !r_s1.inter;
            r_out_pen      <= n_pen;
        end
    end

    assign o_in_stall     = !in_ready;
    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_out_accepted;
    assign o_style_flags  = r_out_pen.style;
    assign o_fore_indexed = r_out_pen.fore_indexed;
    assign o_fore_index   = r_out_pen.fore_index;
    assign o_back_indexed = r_out_pen.back_indexed;
    assign o_back_index   = r_out_pen.back_index;

    `ASSERT_NEXT(a_reject_holds_pen, s1_fire && r_s1.inter, $stable(r_pen), "rejected item changed pen")
    `ASSERT_NEXT(a_empty_resets, s1_fire && r_s1.none && !r_s1.inter, r_pen == '0 && r_seq.base_next, "empty sequence did not reset pen")
    `ASSERT_SAME(a_skip_range, 1'b1, r_seq.skip <= SKIP_RGB, "skip count out of range")
    `ASSERT_SAME(a_result_room, s1_fire && s1_res, out_free, "result register overwritten")

endmodule

>>> sim/tb_sgr_attribute_decoder_core.sv
// Self-checking testbench for the SGR attribute decoder with a pen-tracking scoreboard
`timescale 1ns / 1ps

module tb_sgr_attribute_decoder_core;
    import sgrd_pkg::*;

    typedef struct packed {
        logic accepted;
        t_pen pen;
    } t_pen_report;

    typedef struct {
        logic [15:0] value;
        logic        is_sub;
        logic        is_first;
        logic        is_last;
        logic        is_empty;
        logic        is_rejected;
    } t_param;

    class sgr_pen_tracker;
        t_pen        pen;
        t_seq        seq;
        t_pen_report reports_due[$];
        int          mismatches;
        int          reports_checked;
        int          rejects_checked;

        function new();
            pen = '0;
            seq = SEQ_RESET;
            mismatches = 0;
            reports_checked = 0;
            rejects_checked = 0;
        endfunction

        function int outstanding();
            return reports_due.size();
        endfunction

        function void note_param(t_param p);
            int          code;
            bit          as_base;
            t_pen_report r;
            code = int'(p.value);
            if (!p.is_rejected) begin
                if (p.is_empty) begin
                    pen = '0;
                    seq = SEQ_RESET;
                end else begin
                    if (p.is_first) begin
                        seq = SEQ_RESET;
                    end
                    as_base = 1'b0;
                    if (seq.skip != 3'd0) begin
                        seq.skip = seq.skip - 3'd1;
                        if (seq.skip == 3'd0) begin
                            seq.base_next = 1'b1;
                        end
                    end else if (!seq.base_next && p.is_sub) begin
                        if (seq.kind == KIND_UNDERLINE && code == 0) begin
                            pen.style[ST_UNDER] = 1'b0;
                        end
                        seq.kind = KIND_NONE;
                    end else if (seq.kind == KIND_EXTENDED && !seq.base_next &&
                                 code == SGR_EXT_INDEXED) begin
                        seq.kind = KIND_NONE;
                        seq.skip = SKIP_INDEXED;
                    end else if (seq.kind == KIND_EXTENDED && !seq.base_next &&
                                 code == SGR_EXT_RGB) begin
                        seq.kind = KIND_NONE;
                        seq.skip = SKIP_RGB;
                    end else begin
                        as_base = 1'b1;
                    end
                    if (as_base) begin
                        seq.base_next = 1'b0;
                        seq.kind = KIND_NONE;
                        case (code)
                            SGR_RESET:      pen = '0;
                            SGR_BOLD:       pen.style[ST_BOLD] = 1'b1;
                            SGR_DIM:        pen.style[ST_DIM] = 1'b1;
                            SGR_ITALIC:     pen.style[ST_ITALIC] = 1'b1;
                            SGR_UNDER: begin
                                pen.style[ST_UNDER] = 1'b1;
                                seq.kind = KIND_UNDERLINE;
                            end
                            SGR_BLINK:      pen.style[ST_BLINK] = 1'b1;
                            SGR_REVERSE:    pen.style[ST_REVERSE] = 1'b1;
                            SGR_INVIS:      pen.style[ST_INVIS] = 1'b1;
                            SGR_STRIKE:     pen.style[ST_STRIKE] = 1'b1;
                            SGR_DBL_UNDER:  pen.style[ST_UNDER] = 1'b1;
                            SGR_NORMAL: begin
                                pen.style[ST_BOLD] = 1'b0;
                                pen.style[ST_DIM] = 1'b0;
                            end
                            SGR_NO_ITALIC:  pen.style[ST_ITALIC] = 1'b0;
                            SGR_NO_UNDER:   pen.style[ST_UNDER] = 1'b0;
                            SGR_NO_BLINK:   pen.style[ST_BLINK] = 1'b0;
                            SGR_NO_REVERSE: pen.style[ST_REVERSE] = 1'b0;
                            SGR_NO_INVIS:   pen.style[ST_INVIS] = 1'b0;
                            SGR_NO_STRIKE:  pen.style[ST_STRIKE] = 1'b0;
                            SGR_FG_DEF: begin
                                pen.fore_indexed = 1'b0;
                                pen.fore_index = 4'd0;
                            end
                            SGR_BG_DEF: begin
                                pen.back_indexed = 1'b0;
                                pen.back_index = 4'd0;
                            end
                            SGR_FG_EXT, SGR_BG_EXT, SGR_UL_EXT: seq.kind = KIND_EXTENDED;
                            default: begin
                                if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
                                    pen.fore_indexed = 1'b1;
                                    pen.fore_index = 4'(code - SGR_FG_LO);
                                end else if (code >= SGR_BG_LO && code <= SGR_BG_HI) begin
                                    pen.back_indexed = 1'b1;
                                    pen.back_index = 4'(code - SGR_BG_LO);
                                end else if (code >= SGR_FG_BR_LO && code <= SGR_FG_BR_HI) begin
                                    pen.fore_indexed = 1'b1;
                                    pen.fore_index = 4'(code - SGR_FG_BR_LO + COLOR_BRIGHT);
                                end else if (code >= SGR_BG_BR_LO && code <= SGR_BG_BR_HI) begin
                                    pen.back_indexed = 1'b1;
                                    pen.back_index = 4'(code - SGR_BG_BR_LO + COLOR_BRIGHT);
                                end
                            end
                        endcase
                    end
                end
            end
            if (p.is_empty || p.is_last) begin
                r.accepted = !p.is_rejected;
                r.pen = pen;
                reports_due.push_back(r);
            end
        endfunction

        function void check_report(t_pen_report got);
            t_pen_report want;
            if (reports_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected pen report %h", $realtime, got);
                end
                return;
            end
            want = reports_due.pop_front();
            reports_checked++;
            if (!want.accepted) begin
                rejects_checked++;
            end
            if (got.accepted !== want.accepted || got.pen.style !== want.pen.style ||
                got.pen.fore_indexed !== want.pen.fore_indexed ||
                got.pen.fore_index !== want.pen.fore_index ||
                got.pen.back_indexed !== want.pen.back_indexed ||
                got.pen.back_index !== want.pen.back_index) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: report %0d acc exp %b got %b, style exp %h got %h",
                             $realtime, reports_checked, want.accepted, got.accepted,
                             want.pen.style, got.pen.style);
                    $display("    fg exp %b/%0d got %b/%0d, bg exp %b/%0d got %b/%0d",
                             want.pen.fore_indexed, want.pen.fore_index,
                             got.pen.fore_indexed, got.pen.fore_index,
                             want.pen.back_indexed, want.pen.back_index,
                             got.pen.back_indexed, got.pen.back_index);
                end
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [PARAM_WIDTH_DEF-1:0] i_param_value = '0;
    logic                       i_is_subparam = 1'b0;
    logic                       i_first_param = 1'b0;
    logic                       i_last_param = 1'b0;
    logic                       i_no_params = 1'b0;
    logic                       i_has_intermediates = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic                       o_accepted;
    logic [7:0]                 o_style_flags;
    logic                       o_fore_indexed;
    logic [3:0]                 o_fore_index;
    logic                       o_back_indexed;
    logic [3:0]                 o_back_index;

    sgr_pen_tracker pen_tracker;
    t_param         param_q[$];
    int             send_idle_pct = 10;
    int             recv_idle_pct = 53;
    bit             hold_req = 1'b0;
    int             params_sent = 0;
    int             sequences_sent = 0;

    sgr_attribute_decoder_core #(
        .PARAM_WIDTH(PARAM_WIDTH_DEF)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_param_value      (i_param_value),
        .i_is_subparam      (i_is_subparam),
        .i_first_param      (i_first_param),
        .i_last_param       (i_last_param),
        .i_no_params        (i_no_params),
        .i_has_intermediates(i_has_intermediates),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_accepted         (o_accepted),
        .o_style_flags      (o_style_flags),
        .o_fore_indexed     (o_fore_indexed),
        .o_fore_index       (o_fore_index),
        .o_back_indexed     (o_back_indexed),
        .o_back_index       (o_back_index)
    );

    always #5 i_clk = ~i_clk;

    function automatic void add_param(input logic [15:0] value, input logic is_sub);
        param_q.push_back('{value: value, is_sub: is_sub, is_first: 1'b0, is_last: 1'b0,
                            is_empty: 1'b0, is_rejected: 1'b0});
    endfunction

    function automatic void seal_sequence(input logic rejected);
        param_q[0].is_first = 1'b1;
        param_q[param_q.size()-1].is_last = 1'b1;
        foreach (param_q[i]) begin
            param_q[i].is_rejected = rejected;
        end
    endfunction

    function automatic void build_random_sequence();
        int          parts;
        int          sel;
        logic [15:0] intro;
        sel = $urandom_range(99);
        if (sel < 5) begin
            param_q.push_back('{value: 16'($urandom), is_sub: 1'($urandom),
                                is_first: 1'($urandom), is_last: 1'($urandom),
                                is_empty: 1'b1, is_rejected: ($urandom_range(99) < 20)});
            return;
        end
        parts = $urandom_range(1, 5);
        repeat (parts) begin
            sel = $urandom_range(99);
            case ($urandom_range(2))
                0: intro = 16'(SGR_FG_EXT);
                1: intro = 16'(SGR_BG_EXT);
                default: intro = 16'(SGR_UL_EXT);
            endcase
            if (sel < 55) begin
                add_param(16'($urandom_range(0, 110)), 1'b0);
            end else if (sel < 63) begin
                add_param(16'(SGR_UNDER), 1'b0);
                add_param(16'($urandom_range(0, 3)), 1'b1);
            end else if (sel < 73) begin
                add_param(intro, 1'b0);
                if ($urandom_range(1)) begin
                    add_param(16'(SGR_EXT_INDEXED), 1'b0);
                    add_param(16'($urandom_range(0, 255)), 1'($urandom));
                end else begin
                    add_param(16'(SGR_EXT_RGB), 1'b0);
                    repeat (3) add_param(16'($urandom_range(0, 255)), 1'($urandom));
                end
            end else if (sel < 80) begin
                add_param(intro, 1'b0);
                add_param(16'(SGR_EXT_INDEXED), 1'b1);
                add_param(16'($urandom), 1'b1);
            end else if (sel < 88) begin
                add_param(16'($urandom), 1'($urandom));
            end else begin
                add_param(16'($urandom_range(0, 110)), 1'b1);
            end
        end
        param_q[0].is_first = ($urandom_range(99) >= 4);
        param_q[param_q.size()-1].is_last = ($urandom_range(99) >= 4);
        sel = $urandom_range(99);
        if (sel < 5) begin
            foreach (param_q[i]) param_q[i].is_rejected = 1'b1;
        end else if (sel < 8) begin
            param_q[$urandom_range(param_q.size()-1)].is_rejected = 1'b1;
        end else if (sel < 11) begin
            param_q[$urandom_range(param_q.size()-1)].is_first = 1'b1;
        end
    endfunction

    task automatic put_param(input t_param p);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_param_value       <= p.value;
        i_is_subparam       <= p.is_sub;
        i_first_param       <= p.is_first;
        i_last_param        <= p.is_last;
        i_no_params         <= p.is_empty;
        i_has_intermediates <= p.is_rejected;
        do @(posedge i_clk); while (o_in_stall);
        pen_tracker.note_param(p);
        params_sent++;
    endtask

    task automatic send_sequence();
        foreach (param_q[i]) begin
            put_param(param_q[i]);
        end
        param_q.delete();
        sequences_sent++;
    endtask

    task automatic drain_reports();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pen_tracker.outstanding() != 0);
    endtask

    initial begin
        int          hold_left;
        t_pen_report got;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.accepted         = o_accepted;
                got.pen.style        = o_style_flags;
                got.pen.fore_indexed = o_fore_indexed;
                got.pen.fore_index   = o_fore_index;
                got.pen.back_indexed = o_back_indexed;
                got.pen.back_index   = o_back_index;
                pen_tracker.check_report(got);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int phase_start;
        pen_tracker = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty sequence with the sub, first and last flags also raised
        param_q.push_back('{value: 16'hFFFF, is_sub: 1'b1, is_first: 1'b1, is_last: 1'b1,
                            is_empty: 1'b1, is_rejected: 1'b0});
        send_sequence();
        add_param(16'(SGR_BOLD), 1'b0);
        add_param(16'(SGR_STRIKE), 1'b0);
        add_param(16'(SGR_FG_BR_HI), 1'b0);
        add_param(16'(SGR_BG_BR_HI), 1'b0);
        seal_sequence(1'b0);
        send_sequence();
        add_param(16'(SGR_UNDER), 1'b0);
        add_param(16'd0, 1'b1);
        seal_sequence(1'b0);
        send_sequence();
        add_param(16'(SGR_UNDER), 1'b1);
        add_param(16'(SGR_FG_LO), 1'b0);
        seal_sequence(1'b0);
        send_sequence();
        add_param(16'(SGR_FG_EXT), 1'b0);
        add_param(16'(SGR_EXT_INDEXED), 1'b0);
        add_param(16'hFFFF, 1'b0);
        add_param(16'(SGR_BG_LO), 1'b1);
        seal_sequence(1'b0);
        send_sequence();
        add_param(16'(SGR_BG_EXT), 1'b0);
        add_param(16'(SGR_EXT_RGB), 1'b0);
        add_param(16'd0, 1'b1);
        add_param(16'd255, 1'b0);
        add_param(16'd128, 1'b0);
        seal_sequence(1'b0);
        send_sequence();
        add_param(16'(SGR_UL_EXT), 1'b0);
        add_param(16'(SGR_EXT_INDEXED), 1'b1);
        add_param(16'd7, 1'b1);
        add_param(16'(SGR_DIM), 1'b0);
        seal_sequence(1'b0);
        send_sequence();
        add_param(16'(SGR_RESET), 1'b0);
        seal_sequence(1'b1);
        send_sequence();
        param_q.push_back('{value: 16'h0000, is_sub: 1'b0, is_first: 1'b0, is_last: 1'b0,
                            is_empty: 1'b1, is_rejected: 1'b1});
        send_sequence();
        add_param(16'hFFFF, 1'b0);
        seal_sequence(1'b0);
        send_sequence();
        add_param(16'(SGR_NORMAL), 1'b0);
        add_param(16'(SGR_FG_DEF), 1'b0);
        add_param(16'(SGR_BG_DEF), 1'b0);
        seal_sequence(1'b0);
        send_sequence();
        drain_reports();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 10;
                    recv_idle_pct = 53;
                    hold_req = 1'b1;
                end
                1: begin
                    send_idle_pct = 53;
                    recv_idle_pct = 10;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_start = params_sent;
            while (params_sent - phase_start < 550) begin
                build_random_sequence();
                send_sequence();
            end
            drain_reports();
        end

        repeat (8) @(posedge i_clk);
        $display("Ran %0d parameter transfers in %0d sequences under three idling mixes",
                 params_sent, sequences_sent);
        $display("Checked %0d pen reports, %0d of them rejected sequences",
                 pen_tracker.reports_checked, pen_tracker.rejects_checked);
        if (pen_tracker.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
